@@ rtl/bmm_pkg.sv @@
package bmm_pkg;

  localparam int unsigned RES_W  = 30;
  localparam int unsigned FAC_W  = 31;
  localparam int unsigned PROD_W = 2 * RES_W;
  localparam int unsigned PROD_SHIFT = 29;
  localparam int unsigned QUOT_SHIFT = 31;
  localparam int unsigned TOP_W  = PROD_W - PROD_SHIFT;
  localparam int unsigned EST_W  = TOP_W + FAC_W;
  localparam int unsigned QHAT_W = EST_W - QUOT_SHIFT;
  localparam int unsigned QQ_W   = QHAT_W + RES_W;
  localparam int unsigned REM_W  = QQ_W + 2;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_FACTOR  = 1'b1;

  localparam logic [RES_W-1:0] MODULUS_RST = 30'd1073741823;
  localparam logic [FAC_W-1:0] FACTOR_RST  = 31'd1073741825;

  typedef struct packed {
    logic [RES_W-1:0] a_operand;
    logic [RES_W-1:0] b_operand;
    logic             last_element;
  } bmm_in_t;

  typedef struct packed {
    logic [RES_W-1:0] residue;
    logic             last_out;
  } bmm_out_t;

  typedef struct packed {
    logic [RES_W-1:0] modulus;
    logic [FAC_W-1:0] barrett_factor;
  } bmm_cfg_t;

endpackage

@@ rtl/bmm_pipe.sv @@
module bmm_pipe
  import bmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  bmm_in_t  in_payload,
  input  bmm_cfg_t cfg,
  output logic     out_valid,
  output bmm_out_t out_payload
);

  function automatic logic [REM_W-1:0] cond_sub(input logic [REM_W-1:0] r,
                                                input logic [RES_W-1:0] q);
    logic [REM_W-1:0] qx;
    qx = {{(REM_W-RES_W){1'b0}}, q};
    return (r >= qx) ? (r - qx) : r;
  endfunction

  logic [5:0] vld_r;

  logic [PROD_W-1:0] s1_x_r;
  logic              s1_last_r;

  logic [EST_W-1:0]  s2_est_r;
  logic [PROD_W-1:0] s2_x_r;
  logic              s2_last_r;

  logic [QQ_W-1:0]   s3_qq_r;
  logic [PROD_W-1:0] s3_x_r;
  logic              s3_last_r;

  logic [REM_W-1:0]  s4_rem_r;
  logic              s4_last_r;

  logic [REM_W-1:0]  s5_rem_r;
  logic              s5_last_r;

  bmm_out_t          out_r;

  logic [TOP_W-1:0]  s1_top;
  logic [QHAT_W-1:0] s2_qhat;
  logic [REM_W-1:0]  s6_rem;

  assign s1_top  = s1_x_r[PROD_W-1:PROD_SHIFT];
  assign s2_qhat = s2_est_r[EST_W-1:QUOT_SHIFT];
  assign s6_rem  = cond_sub(s5_rem_r, cfg.modulus);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r    <= PROD_W'(in_payload.a_operand) * PROD_W'(in_payload.b_operand);
    s1_last_r <= in_payload.last_element;

    s2_est_r  <= EST_W'(s1_top) * EST_W'(cfg.barrett_factor);
    s2_x_r    <= s1_x_r;
    s2_last_r <= s1_last_r;

    s3_qq_r   <= QQ_W'(s2_qhat) * QQ_W'(cfg.modulus);
    s3_x_r    <= s2_x_r;
    s3_last_r <= s2_last_r;

    s4_rem_r  <= REM_W'(s3_x_r) - REM_W'(s3_qq_r);
    s4_last_r <= s3_last_r;

    s5_rem_r  <= cond_sub(s4_rem_r, cfg.modulus);
    s5_last_r <= s4_last_r;

    out_r.residue  <= s6_rem[RES_W-1:0];
    out_r.last_out <= s5_last_r;
  end

  assign out_valid   = vld_r[5];
  assign out_payload = out_r;

endmodule

@@ rtl/barrett_modular_multiplier_top.sv @@
// Channel  | Ports                       | Transfer
// ---------+-----------------------------+----------------------------------
// input    | start, busy, in_payload     | start high while busy is low
// result   | out_strobe, out_payload     | out_strobe high, one cycle only
// config   | psel, penable, pwrite, ...  | psel, penable, pwrite, pready high
//
// One item is taken in every cycle; busy is always low.
// Results appear in the order of their input transfers.
// The three multipliers, the remainder subtraction and the two correction
// subtractions take one stage each.
// Synchronous active-low reset clears the pipeline valid bits and loads the
// register reset values. The receiver cannot stall, so nothing is held back.
module barrett_modular_multiplier_top
  import bmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bmm_in_t               in_payload,
  output logic                  out_strobe,
  output bmm_out_t              out_payload,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  bmm_cfg_t cfg_r;
  logic     cfg_wr;
  logic     reg_sel;
  logic     in_xfer;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modulus        <= MODULUS_RST;
      cfg_r.barrett_factor <= FACTOR_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MODULUS: cfg_r.modulus        <= pwdata[RES_W-1:0];
        REG_FACTOR:  cfg_r.barrett_factor <= pwdata[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODULUS: prdata = CFG_DATA_W'(cfg_r.modulus);
      REG_FACTOR:  prdata = CFG_DATA_W'(cfg_r.barrett_factor);
      default:     prdata = '0;
    endcase
  end

  bmm_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_xfer),
    .in_payload  (in_payload),
    .cfg         (cfg_r),
    .out_valid   (out_strobe),
    .out_payload (out_payload)
  );

  // Every accepted item yields exactly one result.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##6 out_strobe)
    else $error("accepted item produced no result");

  // No result appears without a matching input transfer.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_xfer, 6))
    else $error("result without matching input transfer");

  // The flag of a result is the flag of its input transfer.
  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_payload.last_out == $past(in_payload.last_element, 6)))
    else $error("last flag does not match its input");

endmodule
